[sv/sitda_pkg.sv]
// shared constants and types for the signed integer to decimal ascii block
package sitda_pkg;

  localparam int unsigned ValueWidth   = 32;
  localparam int unsigned NumDigits    = 10;
  localparam int unsigned DigitWidth   = 4;
  localparam int unsigned BcdWidth     = NumDigits * DigitWidth;
  localparam int unsigned DabbleStages = 4;
  localparam int unsigned BitsPerStage = ValueWidth / DabbleStages;
  localparam int unsigned CharWidth    = 8;
  localparam int unsigned IdxWidth     = $clog2(NumDigits);

  localparam logic [CharWidth-1:0] AsciiZero  = 8'd48;
  localparam logic [CharWidth-1:0] AsciiMinus = 8'd45;

  // item in flight through the shift-and-add-3 stages
  typedef struct packed {
    logic                  neg;
    logic [BcdWidth-1:0]   bcd;
    logic [ValueWidth-1:0] bin;
  } dabble_t;

  // finished item handed to the character serializer
  typedef struct packed {
    logic                neg;
    logic [IdxWidth-1:0] top;
    logic [BcdWidth-1:0] bcd;
  } ser_load_t;

endpackage

[sv/signed_int_to_decimal_ascii.sv]
// top level: signed 32-bit integer to decimal ascii text, one character per cycle
//
// Raise start with value_i while busy is low to hand over an item. Its text
// leaves on ascii_char_o, one character per cycle marked by valid_o, with last_o
// on the final character: a '-' for negatives, then the digits with no leading
// zeros ('0' for zero, "-2147483648" for the most negative value). The receiver
// cannot stall, so every valid_o cycle must be taken. After acceptance an item
// passes the entry register, four conversion stages, a digit count stage, the
// serializer load and the output register before its first character shows. Each
// item occupies the one-character output serializer while it emits its characters,
// 1 to 11 of them, and that sets the sustained rate; up to six further items
// wait in the conversion pipeline, and busy rises only once that pipeline is
// backed up to its entry register.
module signed_int_to_decimal_ascii
  import sitda_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  logic [ValueWidth-1:0] value_i,
  output logic                  valid_o,
  output logic [CharWidth-1:0]  ascii_char_o,
  output logic                  last_o
);

  // conversion pipeline: stage 0 holds sign and magnitude, stages 1..4 the
  // item after each step of the conversion, each stage moving a quarter of the binary bits
  dabble_t                 st_q   [DabbleStages+1];
  dabble_t                 dab_w  [DabbleStages];
  logic [DabbleStages:0]   st_v_q, st_v_d;
  logic [DabbleStages:0]   st_rdy;

  // digit count stage in front of the serializer
  ser_load_t               cnt_q, cnt_d;
  logic                    cnt_v_q, cnt_v_d;
  logic                    cnt_rdy;

  logic                    ser_rdy;
  logic                    accept;
  logic [ValueWidth-1:0]   mag;
  logic [IdxWidth-1:0]     top_idx;

  // back pressure: a stage may take new data when empty or when it moves on
  always_comb begin
    cnt_rdy = !cnt_v_q || ser_rdy;
    st_rdy[DabbleStages] = !st_v_q[DabbleStages] || cnt_rdy;
    for (int k = DabbleStages - 1; k >= 0; k--) begin
      st_rdy[k] = !st_v_q[k] || st_rdy[k+1];
    end
  end

  assign busy   = !st_rdy[0];
  assign accept = start && !busy;

  // magnitude in unsigned arithmetic, so the most negative value maps to 2^31
  assign mag = value_i[ValueWidth-1] ? (~value_i + ValueWidth'(1)) : value_i;

  generate
    for (genvar g = 0; g < DabbleStages; g++) begin : g_dabble
      sitda_dabble_stage u_dabble (
        .in_i  (st_q[g]),
        .out_o (dab_w[g])
      );
    end
  endgenerate

  always_comb begin
    st_v_d = st_v_q;
    if (st_rdy[0]) begin
      st_v_d[0] = accept;
    end
    for (int k = 1; k <= DabbleStages; k++) begin
      if (st_rdy[k]) begin
        st_v_d[k] = st_v_q[k-1];
      end
    end
    cnt_v_d = cnt_v_q;
    if (cnt_rdy) begin
      cnt_v_d = st_v_q[DabbleStages];
    end
  end

  // index of the most significant nonzero digit, zero when all digits are zero
  always_comb begin
    top_idx = '0;
    for (int d = 0; d < NumDigits; d++) begin
      if (st_q[DabbleStages].bcd[d*DigitWidth +: DigitWidth] != '0) begin
        top_idx = IdxWidth'(d);
      end
    end
    cnt_d.neg = st_q[DabbleStages].neg;
    cnt_d.top = top_idx;
    cnt_d.bcd = st_q[DabbleStages].bcd;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_v_q  <= '0;
      cnt_v_q <= 1'b0;
    end else begin
      st_v_q  <= st_v_d;
      cnt_v_q <= cnt_v_d;
    end
  end

  // payload registers load whenever their stage is free to move
  always_ff @(posedge clk_i) begin
    if (st_rdy[0]) begin
      st_q[0].neg <= value_i[ValueWidth-1];
      st_q[0].bcd <= '0;
      st_q[0].bin <= mag;
    end
    for (int k = 1; k <= DabbleStages; k++) begin
      if (st_rdy[k]) begin
        st_q[k] <= dab_w[k-1];
      end
    end
    if (cnt_rdy) begin
      cnt_q <= cnt_d;
    end
  end

  sitda_serializer u_serializer (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_valid_i (cnt_v_q),
    .load_i       (cnt_q),
    .ready_o      (ser_rdy),
    .valid_o      (valid_o),
    .ascii_char_o (ascii_char_o),
    .last_o       (last_o)
  );

endmodule

[sv/sitda_dabble_stage.sv]
// one slice of the binary to bcd conversion: a fixed number of shift-and-add-3 steps
module sitda_dabble_stage
  import sitda_pkg::*;
(
  input  dabble_t in_i,
  output dabble_t out_o
);

  localparam int unsigned AccWidth = BcdWidth + ValueWidth;

  logic [AccWidth-1:0] acc;

  always_comb begin
    acc = {in_i.bcd, in_i.bin};
    for (int s = 0; s < BitsPerStage; s++) begin
      // digits are independent, adjust all of them before the shift
      for (int d = 0; d < NumDigits; d++) begin
        if (acc[ValueWidth + d*DigitWidth +: DigitWidth] >= 4'd5) begin
          acc[ValueWidth + d*DigitWidth +: DigitWidth] =
            acc[ValueWidth + d*DigitWidth +: DigitWidth] + 4'd3;
        end
      end
      acc = {acc[AccWidth-2:0], 1'b0};
    end
    out_o.neg = in_i.neg;
    out_o.bcd = acc[AccWidth-1 -: BcdWidth];
    out_o.bin = acc[ValueWidth-1:0];
  end

endmodule

[sv/sitda_serializer.sv]
// emits one item's text one character per cycle: sign first, then digits msd to lsd
module sitda_serializer
  import sitda_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 load_valid_i,
  input  ser_load_t            load_i,
  output logic                 ready_o,
  output logic                 valid_o,
  output logic [CharWidth-1:0] ascii_char_o,
  output logic                 last_o
);

  logic                 act_q, act_d;
  logic                 sign_q, sign_d;
  logic [IdxWidth-1:0]  idx_q, idx_d;
  logic [BcdWidth-1:0]  bcd_q, bcd_d;
  logic                 valid_q, valid_d;
  logic [CharWidth-1:0] char_q, char_d;
  logic                 last_q, last_d;
  logic [BcdWidth-1:0]  bcd_shift;
  logic                 done;

  assign bcd_shift = bcd_q >> {idx_q, 2'b00};
  assign done      = act_q && !sign_q && (idx_q == '0);
  assign ready_o   = !act_q || done;

  always_comb begin
    act_d   = act_q;
    sign_d  = sign_q;
    idx_d   = idx_q;
    bcd_d   = bcd_q;
    valid_d = act_q;
    char_d  = char_q;
    last_d  = 1'b0;
    if (act_q) begin
      if (sign_q) begin
        char_d = AsciiMinus;
        sign_d = 1'b0;
      end else begin
        char_d = AsciiZero + {4'd0, bcd_shift[DigitWidth-1:0]};
        last_d = done;
        if (done) begin
          act_d = 1'b0;
        end else begin
          idx_d = idx_q - IdxWidth'(1);
        end
      end
    end
    if (ready_o && load_valid_i) begin
      act_d  = 1'b1;
      sign_d = load_i.neg;
      idx_d  = load_i.top;
      bcd_d  = load_i.bcd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q   <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      act_q   <= act_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sign_q <= sign_d;
    idx_q  <= idx_d;
    bcd_q  <= bcd_d;
    char_q <= char_d;
    last_q <= last_d;
  end

  assign valid_o      = valid_q;
  assign ascii_char_o = char_q;
  assign last_o       = last_q;

endmodule
